@@ rtl/fbpa_pkg.sv @@
// Shared types and codes for the fixed-size block pool allocator.
package fbpa_pkg;

    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int BLOCK_LIMIT = 1024;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [IDX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic [1:0]       status;
    } rsp_t;

endpackage

@@ rtl/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator: bump counter plus a FIFO free list in a link memory.
// A transaction is taken when start is high and busy is low, and its result is shown on
// result for exactly one cycle, marked by result_valid, in the cycle after acceptance;
// the receiver cannot stall it. Frees, clears, bump-counter allocations, allocations of
// the last free-list entry, out-of-memory replies and unused codes leave busy low. An
// allocation that pops a free list holding two or more entries raises busy for an
// extra wait while the synchronous link memory returns the successor of the head.
// The link memory needs no clearing pass, so the block accepts work right after reset.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  fbpa_pkg::req_t             request,
    output logic                       result_valid,
    output fbpa_pkg::rsp_t             result,
    input  logic                       cfg_wr_en,
    input  logic [fbpa_pkg::CNT_W-1:0] cfg_wr_data
);

    localparam int DEPTH  = (MAX_BLOCKS < fbpa_pkg::BLOCK_LIMIT) ?
                            MAX_BLOCKS : fbpa_pkg::BLOCK_LIMIT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [fbpa_pkg::CNT_W-1:0] DEPTH_CNT = fbpa_pkg::CNT_W'(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LINK = 1'b1;

    logic                       state_reg, state_next;
    logic [fbpa_pkg::CNT_W-1:0] block_count_reg;
    logic [fbpa_pkg::CNT_W-1:0] bump_count_reg, bump_count_next;
    logic [fbpa_pkg::IDX_W-1:0] list_head_reg, list_head_next;
    logic [fbpa_pkg::IDX_W-1:0] list_tail_reg, list_tail_next;
    logic                       list_empty_reg, list_empty_next;
    logic                       result_valid_reg;
    fbpa_pkg::rsp_t             result_reg, result_next;

    logic [fbpa_pkg::IDX_W-1:0] link_mem [DEPTH];
    logic [fbpa_pkg::IDX_W-1:0] link_rdata_reg;
    logic                       link_we, link_re;

    logic                       accept;
    logic [fbpa_pkg::CNT_W-1:0] pool_size;

    assign busy         = (state_reg == S_LINK);
    assign accept       = start && !busy;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pool_size    = (block_count_reg > DEPTH_CNT) ? DEPTH_CNT : block_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        bump_count_next = bump_count_reg;
        list_head_next  = list_head_reg;
        list_tail_next  = list_tail_reg;
        list_empty_next = list_empty_reg;
        link_we         = 1'b0;
        link_re         = 1'b0;
        result_next.granted_index = '0;
        result_next.status        = fbpa_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.operation)
                        fbpa_pkg::OP_ALLOC:
                        begin
                            if (bump_count_reg < pool_size)
                            begin
                                result_next.granted_index = bump_count_reg[fbpa_pkg::IDX_W-1:0];
                                bump_count_next = bump_count_reg + fbpa_pkg::CNT_W'(1);
                            end
                            else if (!list_empty_reg)
                            begin
                                result_next.granted_index = list_head_reg;
                                if (list_head_reg == list_tail_reg)
                                begin
                                    list_empty_next = 1'b1;
                                end
                                else
                                begin
                                    // The new head arrives from the link memory next cycle.
                                    link_re    = 1'b1;
                                    state_next = S_LINK;
                                end
                            end
                            else
                            begin
                                result_next.status = fbpa_pkg::ST_OOM;
                            end
                        end
                        fbpa_pkg::OP_FREE:
                        begin
                            if ({1'b0, request.block_index} >= pool_size)
                            begin
                                result_next.status = fbpa_pkg::ST_RANGE;
                            end
                            else if (list_empty_reg)
                            begin
                                list_head_next  = request.block_index;
                                list_tail_next  = request.block_index;
                                list_empty_next = 1'b0;
                            end
                            else
                            begin
                                link_we        = 1'b1;
                                list_tail_next = request.block_index;
                            end
                        end
                        fbpa_pkg::OP_CLEAR:
                        begin
                            list_empty_next = 1'b1;
                            list_head_next  = '0;
                            list_tail_next  = '0;
                            bump_count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LINK:
            begin
                list_head_next = link_rdata_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            block_count_reg  <= fbpa_pkg::CNT_W'(fbpa_pkg::BLOCK_LIMIT);
            bump_count_reg   <= '0;
            list_head_reg    <= '0;
            list_tail_reg    <= '0;
            list_empty_reg   <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            bump_count_reg   <= bump_count_next;
            list_head_reg    <= list_head_next;
            list_tail_reg    <= list_tail_next;
            list_empty_reg   <= list_empty_next;
            result_valid_reg <= accept;
            if (cfg_wr_en)
            begin
                block_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Every queued entry lies below the pool size it was freed under, so it fits the memory.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[list_tail_reg[ADDR_W-1:0]] <= request.block_index;
        end
        if (link_re)
        begin
            link_rdata_reg <= link_mem[list_head_reg[ADDR_W-1:0]];
        end
    end

    a_link_wait_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LINK |=> state_reg == S_IDLE)
        else $error("link read wait lasted more than one cycle");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("accepted transaction produced no result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept))
        else $error("result strobe without an accepted transaction");

    a_link_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        link_re |-> !list_empty_reg && (list_head_reg != list_tail_reg))
        else $error("link read issued on a list with fewer than two entries");

    a_failed_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != fbpa_pkg::ST_OK) |-> result.granted_index == '0)
        else $error("nonzero granted index on a failed transaction");

endmodule

@@ bench/fbpa_checker.sv @@
`timescale 1ns / 100ps
// Checker for the block pool allocator: watches both channels, predicts each reply and compares.
module fbpa_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  fbpa_pkg::req_t             request,
    input  logic                       result_valid,
    input  fbpa_pkg::rsp_t             result,
    input  logic                       cfg_wr_en,
    input  logic [fbpa_pkg::CNT_W-1:0] cfg_wr_data,
    output int                         mismatches,
    output int                         outstanding,
    output int                         bump_grants,
    output int                         list_grants,
    output int                         oom_replies,
    output int                         range_replies
);

    // Shadow copy of the allocator state.
    logic [fbpa_pkg::CNT_W-1:0] pool_blocks;
    logic [fbpa_pkg::IDX_W-1:0] link_table [fbpa_pkg::BLOCK_LIMIT];
    logic [fbpa_pkg::CNT_W-1:0] bumped;
    logic [fbpa_pkg::IDX_W-1:0] head;
    logic [fbpa_pkg::IDX_W-1:0] tail;
    logic                       list_is_empty;

    fbpa_pkg::rsp_t expected_replies [$];

    initial mismatches = 0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Applies one transaction to the shadow state and returns the reply it must produce.
    task automatic predict_reply(input fbpa_pkg::req_t rq, output fbpa_pkg::rsp_t rs);
        int usable;
        usable = (pool_blocks > fbpa_pkg::BLOCK_LIMIT) ? fbpa_pkg::BLOCK_LIMIT
                                                       : int'(pool_blocks);
        rs = '0;
        rs.status = fbpa_pkg::ST_OK;
        case (rq.operation)
            fbpa_pkg::OP_ALLOC:
            begin
                if (int'(bumped) < usable)
                begin
                    rs.granted_index = bumped[fbpa_pkg::IDX_W-1:0];
                    bumped = bumped + fbpa_pkg::CNT_W'(1);
                    bump_grants++;
                end
                else if (!list_is_empty)
                begin
                    rs.granted_index = head;
                    // A lone entry is popped without following its link.
                    if (head == tail)
                        list_is_empty = 1'b1;
                    else
                        head = link_table[head];
                    list_grants++;
                end
                else
                begin
                    rs.status = fbpa_pkg::ST_OOM;
                    oom_replies++;
                end
            end
            fbpa_pkg::OP_FREE:
            begin
                if (int'(rq.block_index) >= usable)
                begin
                    rs.status = fbpa_pkg::ST_RANGE;
                    range_replies++;
                end
                else if (list_is_empty)
                begin
                    head = rq.block_index;
                    tail = rq.block_index;
                    list_is_empty = 1'b0;
                end
                else
                begin
                    link_table[tail] = rq.block_index;
                    tail = rq.block_index;
                end
            end
            fbpa_pkg::OP_CLEAR:
            begin
                list_is_empty = 1'b1;
                head = '0;
                tail = '0;
                bumped = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fbpa_pkg::rsp_t want;
        fbpa_pkg::rsp_t predicted;
        if (!rst_n)
        begin
            pool_blocks = fbpa_pkg::CNT_W'(fbpa_pkg::BLOCK_LIMIT);
            bumped = '0;
            head = '0;
            tail = '0;
            list_is_empty = 1'b1;
            expected_replies.delete();
            bump_grants = 0;
            list_grants = 0;
            oom_replies = 0;
            range_replies = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_replies.size() == 0)
                begin
                    flag_mismatch("reply with no transaction waiting", int'(result.status), -1);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (result.granted_index !== want.granted_index)
                        flag_mismatch("granted_index", int'(result.granted_index),
                                      int'(want.granted_index));
                    if (result.status !== want.status)
                        flag_mismatch("status", int'(result.status), int'(want.status));
                end
            end
            if (cfg_wr_en)
                pool_blocks = cfg_wr_data;
            if (start && !busy)
            begin
                predict_reply(request, predicted);
                expected_replies.push_back(predicted);
            end
            outstanding <= expected_replies.size();
        end
    end

endmodule

@@ bench/tb_fixed_block_pool_allocator.sv @@
`timescale 1ns / 100ps
// Testbench top for the block pool allocator: clock, reset, stimulus, watchdog and verdict.
module tb_fixed_block_pool_allocator;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int MAX_GAP         = 18;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    fbpa_pkg::req_t             request;
    logic                       result_valid;
    fbpa_pkg::rsp_t             result;
    logic                       cfg_wr_en;
    logic [fbpa_pkg::CNT_W-1:0] cfg_wr_data;

    int mismatches;
    int outstanding;
    int bump_grants;
    int list_grants;
    int oom_replies;
    int range_replies;

    int idle_cycles = 0;
    int accepted_ops = 0;
    int pool_settings = 0;
    int pool_limit = fbpa_pkg::BLOCK_LIMIT;
    bit quiet = 1'b0;

    fixed_block_pool_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    fbpa_checker pool_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_valid  (result_valid),
        .result        (result),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .bump_grants   (bump_grants),
        .list_grants   (list_grants),
        .oom_replies   (oom_replies),
        .range_replies (range_replies)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Ends the run if neither a request nor a reply moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
                accepted_ops <= accepted_ops + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Gap before the next request; now and then switch into or out of a back-to-back stretch.
    function automatic int next_gap();
        if ($urandom_range(0, 29) == 0)
            quiet = !quiet;
        return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic fbpa_pkg::req_t make_req(input logic [1:0] op, input int idx);
        fbpa_pkg::req_t r;
        r.operation   = op;
        r.block_index = idx[fbpa_pkg::IDX_W-1:0];
        return r;
    endfunction

    // Presents one transaction and returns at the edge that accepts it.
    task automatic send(input fbpa_pkg::req_t item);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pool(input int blocks);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= blocks[fbpa_pkg::CNT_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        pool_limit = (blocks > fbpa_pkg::BLOCK_LIMIT) ? fbpa_pkg::BLOCK_LIMIT : blocks;
        pool_settings++;
    endtask

    initial
    begin
        int blocks;
        int pick;
        int idx;

        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first at the pool size out of reset.
        send(make_req(OP_UNUSED, fbpa_pkg::BLOCK_LIMIT - 1));
        send(make_req(fbpa_pkg::OP_ALLOC, fbpa_pkg::BLOCK_LIMIT - 1));
        send(make_req(fbpa_pkg::OP_FREE, fbpa_pkg::BLOCK_LIMIT - 1));
        send(make_req(fbpa_pkg::OP_CLEAR, 0));

        set_pool(3);
        repeat (3) send(make_req(fbpa_pkg::OP_ALLOC, 0));
        send(make_req(fbpa_pkg::OP_ALLOC, 0));
        send(make_req(fbpa_pkg::OP_FREE, 3));
        send(make_req(fbpa_pkg::OP_FREE, 2));
        send(make_req(fbpa_pkg::OP_ALLOC, 0));
        send(make_req(fbpa_pkg::OP_FREE, 0));
        send(make_req(fbpa_pkg::OP_FREE, 1));
        send(make_req(fbpa_pkg::OP_FREE, 2));
        repeat (4) send(make_req(fbpa_pkg::OP_ALLOC, 0));
        // The same block is freed twice in a row.
        send(make_req(fbpa_pkg::OP_FREE, 1));
        send(make_req(fbpa_pkg::OP_FREE, 1));
        send(make_req(fbpa_pkg::OP_CLEAR, 0));
        send(make_req(fbpa_pkg::OP_ALLOC, 0));

        set_pool(0);
        send(make_req(fbpa_pkg::OP_ALLOC, 0));
        send(make_req(fbpa_pkg::OP_FREE, 0));

        set_pool(2047);
        send(make_req(fbpa_pkg::OP_FREE, fbpa_pkg::BLOCK_LIMIT - 1));
        send(make_req(fbpa_pkg::OP_ALLOC, 0));

        // Shrinking below the bump count still hands out the queued block beyond the size.
        set_pool(1);
        send(make_req(fbpa_pkg::OP_ALLOC, 0));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       blocks = 1;
                1:       blocks = 2;
                2:       blocks = 3;
                3:       blocks = 5;
                4:       blocks = $urandom_range(6, 40);
                5:       blocks = fbpa_pkg::BLOCK_LIMIT;
                6:       blocks = 0;
                7:       blocks = 4;
                8:       blocks = 2047;
                default: blocks = $urandom_range(0, 2047);
            endcase
            set_pool(blocks);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2 && $urandom_range(0, 1) == 1)
                    drain();
                pick = $urandom_range(0, 99);
                if (pick < 46)
                begin
                    send(make_req(fbpa_pkg::OP_ALLOC,
                                  $urandom_range(0, fbpa_pkg::BLOCK_LIMIT - 1)));
                end
                else if (pick < 90)
                begin
                    if (pool_limit > 0 && $urandom_range(0, 9) < 8)
                        idx = $urandom_range(0, pool_limit - 1);
                    else
                        idx = $urandom_range(0, fbpa_pkg::BLOCK_LIMIT - 1);
                    send(make_req(fbpa_pkg::OP_FREE, idx));
                end
                else if (pick < 94)
                begin
                    send(make_req(fbpa_pkg::OP_CLEAR,
                                  $urandom_range(0, fbpa_pkg::BLOCK_LIMIT - 1)));
                end
                else
                begin
                    send(make_req(OP_UNUSED, $urandom_range(0, fbpa_pkg::BLOCK_LIMIT - 1)));
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d transactions over %0d pool sizes, including empty and clamped pools.",
                 accepted_ops, pool_settings);
        $display("Replies seen: %0d bump grants, %0d free-list grants, %0d out of memory, %s",
                 bump_grants, list_grants, oom_replies,
                 $sformatf("%0d out of range.", range_replies));
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
